// ===== sv/sbde_pkg.sv =====
// Shared types and constants for the sparse bitmap delta encoder.
// Used by sbde_ctrl, sbde_dp and the top level; no dependencies.
`default_nettype none

package sbde_pkg;

  localparam int ROWS_DEF = 16;   // default frame height in rows
  localparam int COLS     = 16;   // pixels per row
  localparam int ROW_W    = 4;    // row index width
  localparam int COL_W    = 4;    // column index width
  localparam int LOC_W    = 9;    // location + 1, up to 256
  localparam int CODE_W   = 10;   // longest code in bits
  localparam int ACC_W    = 17;   // seven leftover bits plus one long code
  localparam int FILL_W   = 5;    // bit count in the accumulator, 0..17
  localparam int CNT_W    = 9;    // entries per frame, up to 256

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_TAIL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } sbde_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch an input row
    logic scan;        // code the current column and advance
    logic emit;        // move a full byte from the accumulator to the hold slot
    logic push_pend;   // send the held byte to the output
    logic pend_last;   // the held byte ends the row's words
    logic push_flush;  // send the partial byte and count, clear the frame
  } sbde_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_full;    // eight or more bits waiting
    logic pend_valid;  // hold slot occupied
    logic obuf_free;   // output register can take a word this cycle
    logic col_last;    // current column is the rightmost
    logic final_row;   // latched final-row flag
  } sbde_stat_t;

endpackage

`default_nettype wire

// ===== sv/sparse_bitmap_delta_encoder.sv =====
// Sparse bitmap delta encoder, top level: joins sbde_ctrl and sbde_dp.
// Depends on sbde_pkg, sbde_ctrl and sbde_dp.
//
// Takes a bitmap one row of 16 pixels per word and codes each set pixel as
// the delta from the previous one (2-bit short code for 1..3, 10-bit long
// code otherwise). Each code enters the bit stream MSB first, and the stream
// fills bytes from bit 0 upward, one byte per output word. A row is accepted,
// then its 16 columns are scanned in turn through the single code unit, the
// scan pausing to move out every byte completed (at most six); the row is
// then closed, and a final row is flushed. Byte moves, the row close and the
// flush can wait while the output side holds out_stall. A final row adds a
// flush word carrying the partial byte, its bit count and the frame's entry
// count; last marks the final word each row produces. The next row is taken
// while the last word still waits in the output register.
`default_nettype none

module sparse_bitmap_delta_encoder
  import sbde_pkg::*;
#(
  parameter int ROWS = ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [COLS-1:0]    row_bits,
  input  wire logic               first_row,
  input  wire logic               final_row,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              stream_byte,
  output logic [3:0]              valid_bits,
  output logic [CNT_W-1:0]        entry_count,
  output logic                    frame_done,
  output logic                    last
);

  sbde_cmd_t  cmd;
  sbde_stat_t stat;

  sbde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbde_dp #(
    .ROWS (ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .row_bits    (row_bits),
    .first_row   (first_row),
    .final_row   (final_row),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stream_byte (stream_byte),
    .valid_bits  (valid_bits),
    .entry_count (entry_count),
    .frame_done  (frame_done),
    .last        (last)
  );

  // at most one step of work per cycle
  a_one_cmd : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.emit, cmd.push_pend, cmd.push_flush}))
    else $error("controller issued overlapping commands");

  // only the flush word carries a partial byte or a count
  a_full_word : assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> valid_bits == 4'd8 && entry_count == '0)
    else $error("non-flush word with partial byte or count");

  a_flush_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last && valid_bits < 4'd8)
    else $error("flush word not marked last or overfull");

  // a word may not be overwritten while the output side holds it
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(cmd.push_pend || cmd.push_flush ||
                                 (cmd.emit && stat.pend_valid)))
    else $error("output word overwritten under stall");

endmodule

`default_nettype wire

// ===== sv/sbde_ctrl.sv =====
// Controller for the sparse bitmap delta encoder: sequences the column scan,
// byte emission and end-of-row steps. Depends on sbde_pkg.
`default_nettype none

module sbde_ctrl
  import sbde_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire sbde_stat_t stat,
  output sbde_cmd_t       cmd
);

  sbde_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.acc_full) begin
          // drain a byte before the next code can fit
          if (!stat.pend_valid || stat.obuf_free) begin
            cmd.emit = 1'b1;
          end
        end else begin
          cmd.scan = 1'b1;
          if (stat.col_last) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (stat.acc_full) begin
          if (!stat.pend_valid || stat.obuf_free) begin
            cmd.emit = 1'b1;
          end
        end else if (stat.pend_valid) begin
          if (stat.obuf_free) begin
            cmd.push_pend = 1'b1;
            cmd.pend_last = !stat.final_row;
            state_next    = stat.final_row ? ST_FLUSH : ST_IDLE;
          end
        end else begin
          state_next = stat.final_row ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat.obuf_free) begin
          cmd.push_flush = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/sbde_dp.sv =====
// Datapath for the sparse bitmap delta encoder: row latch, delta coder,
// bit accumulator, hold slot and output register. Depends on sbde_pkg.
`default_nettype none

module sbde_dp
  import sbde_pkg::*;
#(
  parameter int ROWS = ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [COLS-1:0]    row_bits,
  input  wire logic               first_row,
  input  wire logic               final_row,
  input  wire sbde_cmd_t          cmd,
  output sbde_stat_t              stat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              stream_byte,
  output logic [3:0]              valid_bits,
  output logic [CNT_W-1:0]        entry_count,
  output logic                    frame_done,
  output logic                    last
);

  // short delta: two bits; long delta: two zeros then delta-3 on eight bits,
  // laid out in stream order (earliest bit at bit 0)
  function automatic logic [CODE_W-1:0] stream_code(input logic [LOC_W-1:0] d);
    logic [7:0]        m;
    logic [CODE_W-1:0] w;
    m = 8'(d - 9'd3);
    w = '0;
    if (d <= 9'd3) begin
      w[0] = d[1];
      w[1] = d[0];
    end else begin
      for (int i = 0; i < 8; i++) begin
        w[2 + i] = m[7 - i];
      end
    end
    return w;
  endfunction

  logic [COLS-1:0]   row_q;
  logic              final_q;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row_idx;
  logic [LOC_W-1:0]  lap;
  logic [CNT_W-1:0]  entries;
  logic [ACC_W-1:0]  acc;
  logic [FILL_W-1:0] fill;
  logic [7:0]        pend;
  logic              pend_valid;

  logic [LOC_W-1:0]  loc1;
  logic [LOC_W-1:0]  delta;
  logic              take;
  logic [CODE_W-1:0] code;
  logic [FILL_W-1:0] code_len;
  logic              obuf_free;

  assign loc1     = {1'b0, row_idx, col} + 9'd1;
  assign take     = row_q[col] && (loc1 > lap);
  assign delta    = loc1 - lap;
  assign code     = stream_code(delta);
  assign code_len = (delta <= 9'd3) ? 5'd2 : 5'd10;

  assign obuf_free = !out_valid || !out_stall;

  assign stat.acc_full   = (fill >= 5'd8);
  assign stat.pend_valid = pend_valid;
  assign stat.obuf_free  = obuf_free;
  assign stat.col_last   = (col == COL_W'(COLS - 1));
  assign stat.final_row  = final_q;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.push_pend) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.emit && pend_valid) || cmd.push_pend || cmd.push_flush) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx <= '0;
      lap     <= '0;
      entries <= '0;
      acc     <= '0;
      fill    <= '0;
    end else begin
      if (cmd.load) begin
        if (first_row) begin
          row_idx <= '0;
          lap     <= '0;
          entries <= '0;
          acc     <= '0;
          fill    <= '0;
        end
      end else if (cmd.scan) begin
        if (take) begin
          acc     <= acc | (ACC_W'(code) << fill);
          fill    <= fill + code_len;
          lap     <= loc1;
          entries <= entries + 9'd1;
        end
        // hold the row index at the last row of the frame
        if (stat.col_last && (({1'b0, row_idx} + 5'd1) < 5'(ROWS))) begin
          row_idx <= row_idx + 4'd1;
        end
      end else if (cmd.emit) begin
        acc  <= acc >> 8;
        fill <= fill - 5'd8;
      end else if (cmd.push_flush) begin
        row_idx <= '0;
        lap     <= '0;
        entries <= '0;
        acc     <= '0;
        fill    <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q   <= row_bits;
      final_q <= final_row;
      col     <= '0;
    end else if (cmd.scan) begin
      col <= col + 4'd1;
    end
    if (cmd.emit) begin
      pend <= acc[7:0];
    end
    if (cmd.emit && pend_valid) begin
      stream_byte <= pend;
      valid_bits  <= 4'd8;
      entry_count <= '0;
      frame_done  <= 1'b0;
      last        <= 1'b0;
    end else if (cmd.push_pend) begin
      stream_byte <= pend;
      valid_bits  <= 4'd8;
      entry_count <= '0;
      frame_done  <= 1'b0;
      last        <= cmd.pend_last;
    end else if (cmd.push_flush) begin
      stream_byte <= acc[7:0];
      valid_bits  <= fill[3:0];
      entry_count <= entries;
      frame_done  <= 1'b1;
      last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for sparse_bitmap_delta_encoder: random and directed bitmap rows in,
// coded stream words checked against an in-bench encoder. Needs sbde_pkg and the RTL.
module tb
  import sbde_pkg::*;
();

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ROWS = 230;
  localparam int SETTLE_CYCLES = 60;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int MAX_PRINTED = 100;

  // code layout
  localparam int SHORT_MAX = 3;
  localparam int SHORT_W = 2;
  localparam int LONG_W = 8;
  localparam int LONG_BIAS = 3;

  // receiver stall modes
  localparam int STALL_NONE = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_PERIODIC = 3;

  typedef struct {
    logic [COLS-1:0] bits;
    logic            fst;
    logic            fin;
    logic            drain;  // hold this row until every word is back
  } row_item_t;

  typedef struct {
    logic [7:0]       sbyte;
    logic [3:0]       nbits;
    logic [CNT_W-1:0] count;
    logic             done;
    logic             lst;
  } stream_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COLS-1:0] row_bits = '0;
  logic first_row = 1'b0;
  logic final_row = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] stream_byte;
  logic [3:0] valid_bits;
  logic [CNT_W-1:0] entry_count;
  logic frame_done;
  logic last;

  sparse_bitmap_delta_encoder i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .row_bits(row_bits), .first_row(first_row), .final_row(final_row),
    .out_valid(out_valid), .out_stall(out_stall),
    .stream_byte(stream_byte), .valid_bits(valid_bits),
    .entry_count(entry_count), .frame_done(frame_done), .last(last)
  );

  always #HALF_PERIOD clk = ~clk;

  row_item_t    rows_pending[$];
  stream_word_t words_due[$];
  int err_count = 0;
  logic feed_done = 1'b0;

  // encoder state
  logic [3:0]       enc_row;
  logic [LOC_W-1:0] enc_next_loc;  // previous location + 1, 0 when none yet
  logic [7:0]       enc_byte;
  int               enc_fill;
  logic [CNT_W-1:0] enc_entries;
  stream_word_t     row_words[$];

  task automatic clear_frame();
    enc_row = '0;
    enc_next_loc = '0;
    enc_byte = '0;
    enc_fill = 0;
    enc_entries = '0;
  endtask

  task automatic add_word(logic [7:0] b, int n, logic [CNT_W-1:0] cnt, logic dn);
    stream_word_t w;
    w.sbyte = b;
    w.nbits = n[3:0];
    w.count = cnt;
    w.done = dn;
    w.lst = 1'b0;
    row_words.push_back(w);
  endtask

  task automatic pack_bit(logic b);
    enc_byte[enc_fill] = b;
    enc_fill++;
    if (enc_fill == 8) begin
      add_word(enc_byte, 8, '0, 1'b0);
      enc_byte = '0;
      enc_fill = 0;
    end
  endtask

  task automatic pack_code(int value, int width);
    for (int i = width - 1; i >= 0; i--) pack_bit(value[i]);
  endtask

  task automatic encode_row(logic [COLS-1:0] bits, logic fst, logic fin);
    int loc;
    int delta;
    row_words.delete();
    if (fst) clear_frame();
    for (int c = 0; c < COLS; c++) begin
      if (bits[c]) begin
        loc = (int'(enc_row) << COL_W) | c;
        // drop pixels that do not move past the previous one
        if (loc + 1 > int'(enc_next_loc)) begin
          delta = loc + 1 - int'(enc_next_loc);
          if (delta <= SHORT_MAX) begin
            pack_code(delta, SHORT_W);
          end else begin
            pack_code(0, SHORT_W);
            pack_code(delta - LONG_BIAS, LONG_W);
          end
          enc_next_loc = LOC_W'(loc + 1);
          enc_entries = enc_entries + 1'b1;
        end
      end
    end
    if (int'(enc_row) + 1 < ROWS_DEF) enc_row = enc_row + 1'b1;
    if (fin) begin
      add_word(enc_byte, enc_fill, enc_entries, 1'b1);
      clear_frame();
    end
    if (row_words.size() > 0) row_words[row_words.size() - 1].lst = 1'b1;
    foreach (row_words[i]) words_due.push_back(row_words[i]);
  endtask

  task automatic report(string what, int got, int want);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("tb: mismatch %s: got %0d want %0d", what, got, want);
  endtask

  // sender: bursts with random gaps, payload held while stalled
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    row_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) encode_row(row_bits, first_row, final_row);
      if (in_valid && in_stall) begin
        // hold
      end else if (rows_pending.size() == 0) begin
        in_valid <= 1'b0;
        feed_done <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (rows_pending[0].drain && words_due.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        it = rows_pending.pop_front();
        in_valid <= 1'b1;
        row_bits <= it.bits;
        first_row <= it.fst;
        final_row <= it.fin;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 4);
            2: gap_left = $urandom_range(5, 20);
            default: gap_left = $urandom_range(20, 45);
          endcase
        end
      end
    end
  end

  // receiver: stall mode changes every so often
  int stall_mode = STALL_NONE;
  int stall_span = 0;
  int stall_tick = 0;
  int stall_period = 2;
  always @(posedge clk) begin
    stream_word_t w;
    logic nxt;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          report("word with nothing due, byte", stream_byte, 0);
        end else begin
          w = words_due.pop_front();
          if (stream_byte !== w.sbyte) report("stream_byte", stream_byte, w.sbyte);
          if (valid_bits !== w.nbits) report("valid_bits", valid_bits, w.nbits);
          if (entry_count !== w.count) report("entry_count", entry_count, w.count);
          if (frame_done !== w.done) report("frame_done", frame_done, w.done);
          if (last !== w.lst) report("last", last, w.lst);
        end
      end
      if (stall_span <= 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
        stall_span = $urandom_range(20, 200);
        stall_period = $urandom_range(2, 6);
      end
      stall_span--;
      stall_tick++;
      case (stall_mode)
        STALL_LIGHT: nxt = ($urandom_range(0, 9) < 3);
        STALL_HEAVY: nxt = ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: nxt = (stall_tick % stall_period) == 0;
        default: nxt = 1'b0;
      endcase
      out_stall <= nxt;
    end
  end

  task automatic add_row(logic [COLS-1:0] bits, logic fst, logic fin, logic drain);
    row_item_t it;
    it.bits = bits;
    it.fst = fst;
    it.fin = fin;
    it.drain = drain;
    rows_pending.push_back(it);
  endtask

  function automatic logic [COLS-1:0] pick_row();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2, 3: return COLS'(1) << $urandom_range(0, COLS - 1);
      4, 5: return COLS'($urandom & $urandom & $urandom);
      6: return COLS'($urandom & $urandom);
      7, 8: return COLS'($urandom);
      default: return '1;
    endcase
  endfunction

  initial begin
    int n;
    int len;
    clear_frame();

    // one-row frame with nothing set: empty flush
    add_row('0, 1'b1, 1'b1, 1'b0);
    // full row right after a final row, without first_row
    add_row('1, 1'b0, 1'b1, 1'b0);
    // delta of three, then a row that leaves a partial byte for the flush
    add_row(16'h0004, 1'b1, 1'b0, 1'b0);
    add_row('0, 1'b0, 1'b1, 1'b0);
    // location 255 as first pixel (longest delta), then one row too many
    // whose pixels all fall at or below the previous one and are dropped
    add_row('0, 1'b1, 1'b0, 1'b1);
    for (int r = 1; r < ROWS_DEF - 1; r++) add_row('0, 1'b0, 1'b0, 1'b0);
    add_row(16'h8000, 1'b0, 1'b0, 1'b0);
    add_row('1, 1'b0, 1'b1, 1'b0);

    n = 0;
    while (n < RANDOM_ROWS) begin
      if ($urandom_range(0, 99) < 15) begin
        // noise: any flag combination
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          add_row(COLS'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0);
        n += len;
      end else begin
        case ($urandom_range(0, 9))
          0: len = $urandom_range(ROWS_DEF, ROWS_DEF + 2);
          1: len = $urandom_range(6, 10);
          default: len = $urandom_range(1, 5);
        endcase
        for (int i = 0; i < len; i++)
          add_row(pick_row(), i == 0, i == len - 1,
                  (i == 0) && (n == 0 || $urandom_range(0, 11) == 0));
        n += len;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (!feed_done) @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("tb: done, errors");
    $finish;
  end

endmodule
